[rtl/core/greedy_iou_nms_defines.svh]
// ----------------------------------------------------------------------------
// greedy_iou_nms_defines - assertion macros
// Shared wrappers for the concurrent checks in the NMS block.
// ----------------------------------------------------------------------------
`ifndef GREEDY_IOU_NMS_DEFINES_SVH
`define GREEDY_IOU_NMS_DEFINES_SVH

// Clocked check, quiet while reset is held
`define GNMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define GNMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/gnms_pkg.sv]
// ----------------------------------------------------------------------------
// gnms_pkg - shared types for greedy IoU NMS
// Payload structs, verdict codes, register indexes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int COORD_W   = 16;
  localparam int AREA_W    = 32;
  localparam int THR_W     = 17;
  localparam int MAXDET_W  = 6;
  localparam int COUNT_W   = 7;
  localparam int ONE_SHIFT = 16;   // IoU fraction scale, 2^16
  localparam int UNION_W   = AREA_W + 1;
  localparam int PROD_W    = THR_W + UNION_W;

  localparam logic [THR_W-1:0]    THR_RESET    = 17'd32768;
  localparam logic [MAXDET_W-1:0] MAXDET_RESET = 6'd10;

  // register indexes
  typedef enum logic [0:0] {
    CFG_IOU_THRESHOLD = 1'b0,
    CFG_DET_LIMIT     = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT       = 2'd0,
    VERDICT_SUPPRESSED = 2'd1,
    VERDICT_DROPPED    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
    logic               first_of_list;
  } in_item_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] kept_count;
  } out_item_t;

  // one entry of the kept store: box edges and its area
  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
    logic [AREA_W-1:0]  area;
  } kept_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;     // capture request, clear list on first_of_list
    logic eval;     // area, limit check, reset scan index
    logic issue;    // read one kept entry into the compare pipe
    logic finish;   // commit verdict, update store, load output
  } cmd_t;

  typedef struct packed {
    logic drop;       // list limit reached
    logic scan_more;  // kept entries left to read
    logic pipe_busy;  // compare pipe holds work
    logic out_free;   // output register can take a result
  } status_t;

  // width of an interval, zero when inverted or empty
  function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                              input logic [COORD_W-1:0] hi);
    span = (hi > lo) ? hi - lo : '0;
  endfunction

endpackage

[rtl/core/greedy_iou_nms.sv]
// ----------------------------------------------------------------------------
// greedy_iou_nms - greedy non-maximum suppression by IoU, one class
// Boxes arrive sorted by falling score; each one not dropped is checked
// against each kept box of its list; all get a kept/suppressed/dropped verdict.
// ----------------------------------------------------------------------------
//  channel | ports                           | moves
//  --------+---------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data     | one box request, start-of-list
//  result  | out_valid, out_ready, out_data  | verdict and kept count
//  config  | cfg_we, cfg_index, cfg_data     | threshold / detection limit
//
//  Steps: a request goes through capture, evaluate, a scan of the kept
//    entries of its list, scan end, pipe drain and commit; the scan reads one
//    kept entry per cycle, set by the single read port of the kept store,
//    and is empty while none is kept yet.
//  Dropped requests skip the scan and the drain and go straight to commit.
//  Reset (rst_n low, synchronous): empty list, threshold 0.5, limit 10;
//    the kept store is not cleared, only entries below the kept total are read.
//  Stalls: a finished result sits in the output register; the next request
//    is taken meanwhile and waits at commit only if that register is still full.
// ----------------------------------------------------------------------------
module greedy_iou_nms
  import gnms_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  // register writes
  input  logic             cfg_we,
  input  cfg_index_t       cfg_index,
  input  logic [THR_W-1:0] cfg_data
);

  cmd_t    cmd;      // controller -> datapath
  status_t status;   // datapath -> controller

  // sequencer: idle -> evaluate -> scan kept store -> drain pipe -> commit
  gnms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // store, counters, compare pipe and output register
  gnms_dp #(
    .MAX_KEPT (MAX_KEPT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/gnms_ctrl.sv]
// ----------------------------------------------------------------------------
// gnms_ctrl - sequencing FSM for greedy IoU NMS
// Runs each request through evaluate, scan, drain, commit; drops skip the scan.
// ----------------------------------------------------------------------------
`include "greedy_iou_nms_defines.svh"

module gnms_ctrl
  import gnms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = status.drop ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (!status.scan_more) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!status.pipe_busy) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_SCAN: begin
        cmd.issue = status.scan_more;
      end
      S_DRAIN: begin
        cmd.issue = 1'b0;
      end
      S_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `GNMS_ASSERT(a_drop_skips_scan, (state_r == S_EVAL && status.drop) |=> (state_r == S_FINISH), "dropped request entered scan")
  `GNMS_ASSERT(a_commit_returns_idle, cmd.finish |=> (state_r == S_IDLE && in_ready), "no return to idle after commit")

endmodule

[rtl/core/gnms_dp.sv]
// ----------------------------------------------------------------------------
// gnms_dp - datapath for greedy IoU NMS
// Kept store, list counters, config registers, five-stage IoU compare pipe
// and the output register.
// ----------------------------------------------------------------------------
`include "greedy_iou_nms_defines.svh"

module gnms_dp
  import gnms_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  in_item_t            in_data,
  input  logic                cfg_we,
  input  cfg_index_t          cfg_index,
  input  logic [THR_W-1:0]    cfg_data,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  localparam int AW = $clog2(MAX_KEPT);
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] KEPT_FULL = CW'(MAX_KEPT);
  localparam logic [LW-1:0] KEPT_LIM  = LW'(MAX_KEPT);

  // config
  logic [THR_W-1:0]    thr_r;
  logic [MAXDET_W-1:0] maxdet_r;

  // request and list state
  in_item_t          box_r;
  logic [AREA_W-1:0] area_r;
  logic              drop_r;
  logic              supp_r;
  logic [CW-1:0]     total_r;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     j_r;

  // kept store
  kept_entry_t kept_mem [MAX_KEPT];
  kept_entry_t rd_r;

  // compare pipe
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [COORD_W-1:0] ow_r, oh_r;
  logic [AREA_W-1:0]  karea2_r, karea3_r;
  logic [AREA_W-1:0]  inter3_r, inter4_r, inter5_r;
  logic [UNION_W-1:0] uni4_r;
  logic [PROD_W-1:0]  prod5_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic [LW-1:0]     limit2, limit;
  logic              drop_now;
  logic              keep;
  logic [CW-1:0]     total_nxt;
  logic [AREA_W-1:0] area_new;
  logic [COORD_W-1:0] ox_lo, ox_hi, oy_lo, oy_hi;
  logic [PROD_W-1:0] inter_scaled;

  // list limit: 2*max_detections, saturated at store depth
  assign limit2   = LW'({maxdet_r, 1'b0});
  assign limit    = (limit2 > KEPT_LIM) ? KEPT_LIM : limit2;
  assign drop_now = (LW'(pos_r) >= limit) || (total_r == KEPT_FULL);
  assign keep     = !drop_r && !supp_r;
  assign total_nxt = keep ? total_r + 1'b1 : total_r;
  assign area_new = AREA_W'(span(box_r.x_min, box_r.x_max))
                  * AREA_W'(span(box_r.y_min, box_r.y_max));

  assign ox_lo = (box_r.x_min > rd_r.x_min) ? box_r.x_min : rd_r.x_min;
  assign ox_hi = (box_r.x_max < rd_r.x_max) ? box_r.x_max : rd_r.x_max;
  assign oy_lo = (box_r.y_min > rd_r.y_min) ? box_r.y_min : rd_r.y_min;
  assign oy_hi = (box_r.y_max < rd_r.y_max) ? box_r.y_max : rd_r.y_max;
  assign inter_scaled = PROD_W'({inter5_r, {ONE_SHIFT{1'b0}}});

  assign status.drop      = drop_now;
  assign status.scan_more = (j_r < total_r);
  assign status.pipe_busy = v1_r | v2_r | v3_r | v4_r | v5_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      maxdet_r    <= MAXDET_RESET;
      total_r     <= '0;
      pos_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IOU_THRESHOLD: thr_r    <= cfg_data;
          CFG_DET_LIMIT:     maxdet_r <= cfg_data[MAXDET_W-1:0];
          default:           thr_r    <= thr_r;
        endcase
      end
      if (cmd.load && in_data.first_of_list) begin
        total_r <= '0;
        pos_r   <= '0;
      end
      if (cmd.finish) begin
        total_r <= total_nxt;
        if (pos_r != KEPT_FULL) pos_r <= pos_r + 1'b1;
      end
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) box_r <= in_data;
    if (cmd.eval) begin
      area_r <= area_new;
      drop_r <= drop_now;
      supp_r <= 1'b0;
      j_r    <= '0;
    end
    if (cmd.issue) j_r <= j_r + 1'b1;
    if (v5_r && (inter_scaled > prod5_r)) supp_r <= 1'b1;
    if (cmd.finish) begin
      out_r.verdict    <= drop_r ? VERDICT_DROPPED
                        : (supp_r ? VERDICT_SUPPRESSED : VERDICT_KEPT);
      out_r.kept_count <= COUNT_W'(total_nxt);
    end
  end

  // kept store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.finish && keep) begin
      kept_mem[total_r[AW-1:0]] <= '{x_min: box_r.x_min, y_min: box_r.y_min,
                                     x_max: box_r.x_max, y_max: box_r.y_max,
                                     area: area_r};
    end
    if (cmd.issue) rd_r <= kept_mem[j_r[AW-1:0]];
  end

  // compare pipe: overlap, intersection, union, threshold product
  always_ff @(posedge clk) begin
    ow_r     <= span(ox_lo, ox_hi);
    oh_r     <= span(oy_lo, oy_hi);
    karea2_r <= rd_r.area;
    inter3_r <= AREA_W'(ow_r) * AREA_W'(oh_r);
    karea3_r <= karea2_r;
    uni4_r   <= UNION_W'(area_r) + UNION_W'(karea3_r) - UNION_W'(inter3_r);
    inter4_r <= inter3_r;
    prod5_r  <= PROD_W'(thr_r) * PROD_W'(uni4_r);
    inter5_r <= inter4_r;
  end

  `GNMS_ASSERT_ALWAYS(a_total_bounded, (total_r <= KEPT_FULL) || !rst_n, "kept total beyond store depth")
  `GNMS_ASSERT(a_commit_sets_output, cmd.finish |=> out_valid_r, "commit did not present a result")

endmodule

[dv/greedy_iou_nms_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// greedy_iou_nms_tb - self-checking bench for greedy IoU NMS
// Box requests are pushed through the valid/ready input channel with random
// gaps. Each accepted request is scored by a local model of the kept set, and
// every returned verdict and kept count is compared with the oldest
// prediction. Threshold and detection limit are reprogrammed between phases.
// ----------------------------------------------------------------------------
module greedy_iou_nms_tb;
  import gnms_pkg::*;

  localparam int KEPT_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  cfg_index_t       cfg_index = CFG_IOU_THRESHOLD;
  logic [THR_W-1:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  greedy_iou_nms #(
    .MAX_KEPT (KEPT_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  in_item_t  pending_boxes[$];     // requests not yet presented
  out_item_t expected_verdicts[$]; // predictions awaiting a result
  int        boxes_in_flight = 0;  // queued by stimulus, result not yet seen
  int        fail_count      = 0;
  int        cycle_count     = 0;

  // idle mode, redrawn every stretch of requests; off means back-to-back
  bit        idle_on         = 1'b1;
  int        stretch_left    = 40;
  int        send_gap        = 0;
  int        ready_hold      = 0;

  // --------------------------------------------------------------------------
  // Local NMS model: kept set, list position and register copies
  // --------------------------------------------------------------------------
  kept_entry_t         kept_store[KEPT_DEPTH];
  int                  kept_total = 0;
  int                  list_pos   = 0;
  logic [THR_W-1:0]    model_thr  = THR_RESET;
  logic [MAXDET_W-1:0] model_mdet = MAXDET_RESET;

  // interval length, zero when inverted
  function automatic logic [31:0] interval_len(logic [15:0] lo, logic [15:0] hi);
    return (hi > lo) ? 32'(hi - lo) : 32'd0;
  endfunction

  function automatic logic [31:0] overlap_len(logic [15:0] a0, logic [15:0] a1,
                                              logic [15:0] b0, logic [15:0] b1);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return interval_len(lo, hi);
  endfunction

  // Scores one box against the kept set and updates the model state.
  function automatic out_item_t judge_box(in_item_t b);
    logic [31:0] area;
    logic [63:0] inter;
    logic [63:0] uni;
    int          lim;
    bit          keep;
    out_item_t   r;
    if (b.first_of_list) begin
      kept_total = 0;
      list_pos   = 0;
    end
    lim = 2 * int'(model_mdet);
    if (lim > KEPT_DEPTH) lim = KEPT_DEPTH;
    if (list_pos >= lim || kept_total >= KEPT_DEPTH) begin
      r.verdict = VERDICT_DROPPED;
    end else begin
      area = interval_len(b.x_min, b.x_max) * interval_len(b.y_min, b.y_max);
      keep = 1'b1;
      for (int j = 0; j < kept_total; j++) begin
        inter = 64'(overlap_len(b.x_min, b.x_max, kept_store[j].x_min, kept_store[j].x_max))
              * 64'(overlap_len(b.y_min, b.y_max, kept_store[j].y_min, kept_store[j].y_max));
        uni   = 64'(area) + 64'(kept_store[j].area) - inter;
        if ((inter << 16) > 64'(model_thr) * uni) keep = 1'b0;
      end
      if (keep) begin
        kept_store[kept_total] = '{b.x_min, b.y_min, b.x_max, b.y_max, area};
        kept_total++;
        r.verdict = VERDICT_KEPT;
      end else begin
        r.verdict = VERDICT_SUPPRESSED;
      end
    end
    if (list_pos < KEPT_DEPTH) list_pos++;
    r.kept_count = COUNT_W'(kept_total);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int idle_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued box requests, predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.insert(expected_verdicts.size(), judge_box(in_data));
        send_gap = idle_on ? idle_cycles() : 0;
        stretch_left--;
        if (stretch_left <= 0) begin
          stretch_left = $urandom_range(20, 80);
          idle_on      = ($urandom_range(0, 3) != 0);
        end
      end
      // slot is free unless a request is still waiting for ready
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_boxes.size() != 0) begin
          in_data  <= pending_boxes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result with oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          note_failure($sformatf("result with nothing expected: verdict %0d count %0d",
                                 out_data.verdict, out_data.kept_count));
        end else begin
          out_item_t want;
          want = expected_verdicts.pop_front();
          if (out_data.verdict !== want.verdict || out_data.kept_count !== want.kept_count)
            note_failure($sformatf("verdict exp %0d got %0d, kept_count exp %0d got %0d",
                                   want.verdict, out_data.verdict,
                                   want.kept_count, out_data.kept_count));
        end
        boxes_in_flight--;
      end
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (!idle_on || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        ready_hold = idle_on ? $urandom_range(0, 7) : 0;
      end else begin
        out_ready <= 1'b0;
        ready_hold = idle_cycles();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding",
               cycle_count, boxes_in_flight);
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // list cluster: boxes of a list scatter around this centre
  int       centre_x = 30000;
  int       centre_y = 30000;
  int       spread   = 500;
  in_item_t last_box = '0;

  function automatic logic [15:0] clamp16(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic in_item_t make_box(bit first);
    in_item_t b;
    int       kind;
    int       mx;
    int       my;
    int       hw;
    int       hh;
    kind = $urandom_range(0, 15);
    mx   = centre_x + int'($urandom_range(0, 2 * spread)) - spread;
    my   = centre_y + int'($urandom_range(0, 2 * spread)) - spread;
    hw   = $urandom_range(2, 3000);
    hh   = $urandom_range(2, 3000);
    b    = '{clamp16(mx - hw), clamp16(my - hh), clamp16(mx + hw), clamp16(my + hh), 1'b0};
    case (kind)
      10, 11: begin // anything at all, inverted sides included
        b = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
      end
      12: begin // inverted
        b = '{clamp16(mx + hw), clamp16(my + hh), clamp16(mx - hw), clamp16(my - hh), 1'b0};
      end
      13: begin // shares the right edge of the previous box
        b.x_min = last_box.x_max;
        b.x_max = clamp16(int'(last_box.x_max) + hw);
        b.y_min = last_box.y_min;
        b.y_max = last_box.y_max;
      end
      14: b = last_box; // repeat
      15: b.x_max = b.x_min; // zero width
      default: ;
    endcase
    b.first_of_list = first;
    last_box = b;
    return b;
  endfunction

  task automatic queue_box(input int x0, input int y0, input int x1, input int y1,
                           input bit first);
    pending_boxes.insert(pending_boxes.size(), '{16'(x0), 16'(y0), 16'(x1), 16'(y1), first});
    boxes_in_flight++;
  endtask

  task automatic wait_idle();
    while (boxes_in_flight != 0) @(posedge clk);
  endtask

  // register write, only once every request has its result
  task automatic set_reg(input cfg_index_t idx, input logic [THR_W-1:0] val);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IOU_THRESHOLD: model_thr  = val;
      CFG_DET_LIMIT:     model_mdet = val[MAXDET_W-1:0];
      default: ;
    endcase
  endtask

  // well-formed lists with random content, a few continuing without a start
  task automatic run_phase(input int n);
    int done;
    int len;
    int lim;
    bit first;
    done = 0;
    lim  = 2 * int'(model_mdet);
    while (done < n) begin
      centre_x = $urandom_range(0, 65535);
      centre_y = $urandom_range(0, 65535);
      spread   = ($urandom_range(0, 3) == 0) ? $urandom_range(2000, 30000)
                                             : $urandom_range(20, 2000);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, lim + 6);
      else len = $urandom_range(1, (lim > 2) ? lim : 2);
      if (len > n - done) len = n - done;
      first = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len; i++) begin
        pending_boxes.insert(pending_boxes.size(), make_box(first && i == 0));
        boxes_in_flight++;
      end
      done += len;
    end
  endtask

  initial begin
    logic [THR_W-1:0]    thr;
    logic [MAXDET_W-1:0] mdet;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, no start flag on the first box
    queue_box(0, 0, 100, 100, 1'b0);          // kept
    queue_box(0, 0, 100, 100, 1'b0);          // identical: suppressed
    queue_box(100, 0, 200, 100, 1'b0);        // touching edge
    queue_box(500, 500, 400, 400, 1'b0);      // inverted, area zero
    queue_box(400, 400, 400, 400, 1'b0);      // zero area against zero area
    queue_box(0, 0, 65535, 65535, 1'b0);      // full frame
    queue_box(65535, 65535, 0, 0, 1'b0);      // fully inverted extreme
    queue_box(65535, 65535, 65535, 65535, 1'b0);
    queue_box(0, 0, 65535, 65535, 1'b1);      // new list
    queue_box(0, 0, 65535, 32768, 1'b0);      // just above one half
    queue_box(0, 0, 65535, 32767, 1'b0);      // just below one half

    // limit of two, then raised mid-list
    set_reg(CFG_DET_LIMIT, 17'd1);
    queue_box(0, 0, 10, 10, 1'b1);
    queue_box(20, 20, 30, 30, 1'b0);
    queue_box(40, 40, 50, 50, 1'b0);          // past the limit
    set_reg(CFG_DET_LIMIT, 17'd2);
    queue_box(60, 60, 70, 70, 1'b0);          // new limit admits it

    // zero limit drops everything
    set_reg(CFG_DET_LIMIT, 17'd0);
    queue_box(0, 0, 10, 10, 1'b1);
    queue_box(20, 20, 30, 30, 1'b0);

    // zero threshold: any overlap suppresses
    set_reg(CFG_DET_LIMIT, 17'd10);
    set_reg(CFG_IOU_THRESHOLD, 17'd0);
    queue_box(0, 0, 100, 100, 1'b1);
    queue_box(99, 99, 200, 200, 1'b0);

    // top threshold never suppresses
    set_reg(CFG_IOU_THRESHOLD, 17'h1FFFF);
    queue_box(0, 0, 100, 100, 1'b1);
    queue_box(0, 0, 100, 100, 1'b0);

    // random phases, extreme settings first
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin thr = 17'd65536; mdet = 6'd63; end  // fills the whole store
        1: begin thr = 17'd0;     mdet = 6'd32; end
        2: begin thr = 17'h1FFFF; mdet = 6'd1;  end
        3: begin thr = 17'($urandom_range(0, 65536)); mdet = 6'd0; end
        default: begin
          thr  = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 131071))
                                             : 17'($urandom_range(0, 65536));
          mdet = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(33, 63))
                                             : 6'($urandom_range(1, 32));
        end
      endcase
      set_reg(CFG_IOU_THRESHOLD, thr);
      set_reg(CFG_DET_LIMIT, 17'(mdet));
      if (p == 0) run_phase(140);
      else if (mdet == 0) run_phase(20);
      else run_phase(80);
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (expected_verdicts.size() != 0)
      note_failure($sformatf("%0d predictions never answered", expected_verdicts.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
